### src/sidb_pkg.sv
package sidb_pkg;

   // Width of one binary-coded decimal digit.
   localparam int DIGIT_BITS = 4;

   // ASCII codes used in the text.
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SKIP,
      ST_EMIT
   } state_type;

   // Commands from the sequencer to the shift/add-3 unit.
   typedef struct packed {
      logic load;        // Take a new magnitude and clear the digits.
      logic dabble;      // One shift-and-add-3 step.
      logic digit_shift; // Drop the top digit, move the rest up.
   } ctrl_type;

endpackage

### src/sidb_dabble.sv
module sidb_dabble #(
   parameter int VALUE_BITS = 16,
   parameter int NUM_DIGITS = 5
) (
   input  logic                                      clock,
   input  sidb_pkg::ctrl_type                        ctrl,
   input  logic [VALUE_BITS-1:0]                     load_mag,
   output logic [sidb_pkg::DIGIT_BITS-1:0]           top_digit
);
   import sidb_pkg::*;

   localparam int BCD_BITS = NUM_DIGITS * DIGIT_BITS;

   logic [VALUE_BITS-1:0] mag_ff, mag_in;
   logic [BCD_BITS-1:0]   bcd_ff, bcd_in;
   logic [BCD_BITS-1:0]   adjusted;

   // Add three to every digit of five or more before the shift.
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (bcd_ff[i*DIGIT_BITS +: DIGIT_BITS] >= 4'd5) begin
            adjusted[i*DIGIT_BITS +: DIGIT_BITS] =
               bcd_ff[i*DIGIT_BITS +: DIGIT_BITS] + 4'd3;
         end else begin
            adjusted[i*DIGIT_BITS +: DIGIT_BITS] = bcd_ff[i*DIGIT_BITS +: DIGIT_BITS];
         end
      end
   end

   // Select the operation the sequencer asks for.
   always_comb begin
      mag_in = mag_ff;
      bcd_in = bcd_ff;
      if (ctrl.load) begin
         mag_in = load_mag;
         bcd_in = '0;
      end else if (ctrl.dabble) begin
         mag_in = {mag_ff[VALUE_BITS-2:0], 1'b0};
         bcd_in = {adjusted[BCD_BITS-2:0], mag_ff[VALUE_BITS-1]};
      end else if (ctrl.digit_shift) begin
         bcd_in = {bcd_ff[BCD_BITS-DIGIT_BITS-1:0], {DIGIT_BITS{1'b0}}};
      end
   end

   // Working registers carry payload only and need no reset.
   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      bcd_ff <= bcd_in;
   end

   assign top_digit = bcd_ff[BCD_BITS-1 -: DIGIT_BITS];

endmodule

### src/signed_int_to_decimal_ascii.sv
// Converts one signed two's-complement integer per request into its decimal
// ASCII text, sent one character per response, most significant first, with a
// leading '-' for negative values and rsp_last on the final character. The
// magnitude is handled unsigned, so the most negative value converts exactly.
// Each request runs the shift-and-add-3 steps, one per magnitude bit, in one shared
// digit unit, then drops suppressed leading zeros, then sends one character per
// response while rsp_stall is low.
// req_stall stays high from acceptance until the final character has entered
// the output register; that character may still wait there while the next
// request is taken.
module signed_int_to_decimal_ascii #(
   parameter int VALUE_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [VALUE_BITS-1:0] req_value,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_character,
   output logic                  rsp_last
);
   import sidb_pkg::*;

   // Decimal digits of 2^(VALUE_BITS-1); 0.301 approximates log10(2).
   localparam int NUM_DIGITS = (VALUE_BITS * 301) / 1000 + 1;
   localparam int CNT_BITS   = $clog2(VALUE_BITS + 1);

   state_type             state_ff, state_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic                  sign_ff, sign_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            rsp_character_ff, rsp_character_in;
   logic                  rsp_last_ff, rsp_last_in;
   ctrl_type              ctrl;
   logic [VALUE_BITS-1:0] magnitude;
   logic [DIGIT_BITS-1:0] top_digit;
   logic                  out_free;
   logic                  cnt_one;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign cnt_one   = (cnt_ff == CNT_BITS'(1));
   assign magnitude = req_value[VALUE_BITS-1] ? (~req_value + VALUE_BITS'(1)) : req_value;

   sidb_dabble #(
      .VALUE_BITS(VALUE_BITS),
      .NUM_DIGITS(NUM_DIGITS)
   ) u_dabble (
      .clock     (clock),
      .ctrl      (ctrl),
      .load_mag  (magnitude),
      .top_digit (top_digit)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            if (cnt_one) begin
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if (top_digit != '0 || cnt_one) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free && !sign_ff && cnt_one) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs, counter and output register loads.
   always_comb begin
      ctrl             = '0;
      cnt_in           = cnt_ff;
      sign_in          = sign_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_character_in = rsp_character_ff;
      rsp_last_in      = rsp_last_ff;
      req_stall        = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               ctrl.load = 1'b1;
               cnt_in    = CNT_BITS'(VALUE_BITS);
               sign_in   = req_value[VALUE_BITS-1];
            end
         end
         ST_CONVERT: begin
            ctrl.dabble = 1'b1;
            cnt_in      = cnt_one ? CNT_BITS'(NUM_DIGITS) : cnt_ff - CNT_BITS'(1);
         end
         ST_SKIP: begin
            // Drop leading zeros, but always keep the ones digit.
            if (top_digit == '0 && !cnt_one) begin
               ctrl.digit_shift = 1'b1;
               cnt_in           = cnt_ff - CNT_BITS'(1);
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (sign_ff) begin
                  rsp_character_in = CHAR_MINUS;
                  rsp_last_in      = 1'b0;
                  sign_in          = 1'b0;
               end else begin
                  rsp_character_in = CHAR_ZERO + {4'b0000, top_digit};
                  rsp_last_in      = cnt_one;
                  ctrl.digit_shift = 1'b1;
                  cnt_in           = cnt_ff - CNT_BITS'(1);
               end
            end
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cnt_ff           <= cnt_in;
      sign_ff          <= sign_in;
      rsp_character_ff <= rsp_character_in;
      rsp_last_ff      <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_character_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

### src/sidb_checker.sv
module sidb_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [7:0]            rsp_character,
   input logic                  rsp_last
);
   import sidb_pkg::*;

   // A stalled response holds its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_character) && $stable(rsp_last))
      else $error("stalled response changed");

   // A request is never taken right after another, since req_stall rises while it converts.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while converting");

   // Every character is a minus sign or a decimal digit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_character == CHAR_MINUS) ||
                    (rsp_character >= CHAR_ZERO && rsp_character <= CHAR_NINE))
      else $error("character outside the decimal alphabet");

   // A minus sign is never the final character.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_character == CHAR_MINUS |-> !rsp_last)
      else $error("minus sign marked as last");

endmodule

bind signed_int_to_decimal_ascii sidb_checker u_sidb_checker (.*);
